// ----- src/remote_link_frame_engine_macros.svh -----
// Assertion helpers used by the engine's datapath.
`ifndef REMOTE_LINK_FRAME_ENGINE_MACROS_SVH
`define REMOTE_LINK_FRAME_ENGINE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define RLFE_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Cause in one cycle implies an effect in the next.
`define RLFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rlfe_pkg.sv -----
`timescale 1ns / 1ps
package rlfe_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned MAX_PAYLOAD_DEF = 10;
    localparam int unsigned PAYLOAD_BITS    = 80;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_RX   = 2'd1;
    localparam logic [1:0] KIND_HOST = 2'd2;

    localparam logic [7:0] BYTE_RTS       = 8'hF0;
    localparam logic [7:0] BYTE_CTS       = 8'hF8;
    localparam logic [7:0] BYTE_ACK       = 8'hFA;
    localparam logic [7:0] BYTE_ACK_ODD   = 8'hFB;
    localparam logic [7:0] BYTE_SOF       = 8'hFD;
    localparam logic [7:0] BYTE_EOF       = 8'hFE;
    localparam logic [7:0] CODE_QUERY     = 8'h02;
    localparam logic [7:0] CODE_INIT      = 8'h80;
    localparam logic [7:0] CODE_ID        = 8'h82;
    localparam logic [7:0] CODE_KEYS      = 8'h84;
    localparam logic [7:0] QUERY_ARG_KEYS = 8'h01;
    localparam logic [7:0] PHASE_MASK     = 8'hFE;

    typedef enum logic [2:0] {
        FAULT_NONE       = 3'd0,
        FAULT_UNEXP_ACK  = 3'd1,
        FAULT_ACK_PHASE  = 3'd2,
        FAULT_NO_END     = 3'd3,
        FAULT_QUEUE_FULL = 3'd4
    } t_fault;

    typedef enum logic [2:0] {
        PS_IDLE = 3'd0,
        PS_CODE = 3'd1,
        PS_ARG  = 3'd2,
        PS_CHK  = 3'd3,
        PS_END  = 3'd4,
        PS_SKIP = 3'd5
    } t_parse;

    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_HOST,
        SRC_INIT,
        SRC_ID,
        SRC_KEYS
    } t_push_src;

    typedef enum logic [2:0] {
        EM_SINGLE,
        EM_SOF,
        EM_CODE,
        EM_DATA,
        EM_CHECK,
        EM_EOF
    } t_emit_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PLAN,
        ST_PUSH_HDR,
        ST_PUSH_BYTE,
        ST_PUSH_END,
        ST_SEND_CHECK,
        ST_HDR_WAIT,
        ST_EMIT_SOF,
        ST_EMIT_CODE,
        ST_DATA_WAIT,
        ST_EMIT_DATA,
        ST_EMIT_CHECK,
        ST_EMIT_EOF,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic        line_powered;
        logic [7:0]  rx_byte;
        logic [7:0]  cmd_code;
        logic [3:0]  cmd_len;
        logic [63:0] payload_low;
        logic [15:0] payload_high;
    } t_in_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic       link_online;
        logic [2:0] fault;
        logic       rx_cmd_valid;
        logic [7:0] rx_cmd;
        logic [4:0] queue_level;
    } t_out_item;

    typedef struct packed {
        logic      decode;
        logic      push_hdr;
        logic      push_byte;
        logic      push_end;
        logic      rts_req;
        logic      emit;
        t_emit_sel emit_sel;
    } t_dp_cmd;

    typedef struct packed {
        t_push_src push_src;
        logic      plan_send;
        logic      push_stop;
        logic      push_idx_last;
        logic      send_skip;
        logic      cts;
        logic      frame_empty;
        logic      frame_idx_last;
        logic      out_free;
    } t_dp_status;

endpackage

// ----- src/rlfe_in_if.sv -----
`timescale 1ns / 1ps
interface rlfe_in_if import rlfe_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/rlfe_out_if.sv -----
`timescale 1ns / 1ps
interface rlfe_out_if import rlfe_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/rlfe_ram.sv -----
`timescale 1ns / 1ps
module rlfe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/rlfe_ctrl.sv -----
`timescale 1ns / 1ps
module rlfe_ctrl import rlfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: n_state = ST_PLAN;
            ST_PLAN: begin
                if (i_status.push_src != SRC_NONE) n_state = ST_PUSH_HDR;
                else if (i_status.plan_send)       n_state = ST_SEND_CHECK;
                else                               n_state = ST_FINAL;
            end
            ST_PUSH_HDR: n_state = i_status.push_stop ? ST_PUSH_END : ST_PUSH_BYTE;
            ST_PUSH_BYTE: begin
                if (i_status.push_idx_last) n_state = ST_PUSH_END;
            end
            ST_PUSH_END: n_state = ST_PLAN;
            ST_SEND_CHECK: begin
                if (i_status.send_skip || !i_status.cts) n_state = ST_FINAL;
                else                                     n_state = ST_HDR_WAIT;
            end
            ST_HDR_WAIT: n_state = ST_EMIT_SOF;
            ST_EMIT_SOF: begin
                if (i_status.out_free) n_state = ST_EMIT_CODE;
            end
            ST_EMIT_CODE: begin
                if (i_status.out_free) begin
                    n_state = i_status.frame_empty ? ST_EMIT_CHECK : ST_DATA_WAIT;
                end
            end
            ST_DATA_WAIT: n_state = ST_EMIT_DATA;
            ST_EMIT_DATA: begin
                if (i_status.out_free) begin
                    n_state = i_status.frame_idx_last ? ST_EMIT_CHECK : ST_DATA_WAIT;
                end
            end
            ST_EMIT_CHECK: begin
                if (i_status.out_free) n_state = ST_EMIT_EOF;
            end
            ST_EMIT_EOF: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            ST_FINAL: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.emit_sel = EM_SINGLE;
        case (r_state)
            ST_IDLE:       o_in_ready = 1'b1;
            ST_DECODE:     o_cmd.decode = 1'b1;
            ST_PUSH_HDR:   o_cmd.push_hdr = 1'b1;
            ST_PUSH_BYTE:  o_cmd.push_byte = 1'b1;
            ST_PUSH_END:   o_cmd.push_end = 1'b1;
            ST_SEND_CHECK: o_cmd.rts_req = !i_status.send_skip && !i_status.cts;
            ST_EMIT_SOF: begin
                o_cmd.emit     = 1'b1;
                o_cmd.emit_sel = EM_SOF;
            end
            ST_EMIT_CODE: begin
                o_cmd.emit     = 1'b1;
                o_cmd.emit_sel = EM_CODE;
            end
            ST_EMIT_DATA: begin
                o_cmd.emit     = 1'b1;
                o_cmd.emit_sel = EM_DATA;
            end
            ST_EMIT_CHECK: begin
                o_cmd.emit     = 1'b1;
                o_cmd.emit_sel = EM_CHECK;
            end
            ST_EMIT_EOF: begin
                o_cmd.emit     = 1'b1;
                o_cmd.emit_sel = EM_EOF;
            end
            ST_FINAL: begin
                o_cmd.emit     = 1'b1;
                o_cmd.emit_sel = EM_SINGLE;
            end
            default: o_in_ready = 1'b0;
        endcase
    end
endmodule

// ----- src/rlfe_dp.sv -----
`timescale 1ns / 1ps
`include "remote_link_frame_engine_macros.svh"
module rlfe_dp import rlfe_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_accept,
    input  t_in_item   i_in_data,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_out_item  o_out_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status
);
    localparam int unsigned PW  = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IW  = $clog2(MAX_PAYLOAD);
    localparam int unsigned PAD = QUEUE_DEPTH * MAX_PAYLOAD;
    localparam int unsigned PAW = $clog2(PAD);

    function automatic logic [7:0] id_byte(input logic [IW-1:0] idx);
        logic [7:0] b;
        case (idx)
            IW'(0):  b = 8'h01;
            IW'(1):  b = 8'hA8;
            IW'(2):  b = 8'h00;
            IW'(3):  b = 8'h47;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    t_in_item   r_item;
    logic       r_online, n_online;
    logic       r_rts, n_rts;
    logic       r_cts, n_cts;
    logic       r_await, n_await;
    logic       r_rx_phase, n_rx_phase;
    logic       r_tx_phase, n_tx_phase;
    t_parse     r_parse, n_parse;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    t_fault     r_fault, n_fault;
    logic       r_cmd_valid, n_cmd_valid;
    logic [7:0] r_cmd, n_cmd;
    t_push_src  r_push_src, n_push_src;
    logic       r_plan_send, n_plan_send;
    logic       r_emit1_v, n_emit1_v;
    logic [7:0] r_emit1_byte, n_emit1_byte;
    logic       r_push_ok, n_push_ok;
    logic [IW-1:0] r_idx, n_idx;
    logic [7:0] r_ck, n_ck;
    logic [3:0] r_flen, n_flen;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;

    logic [PAYLOAD_BITS-1:0] w_payload;
    logic [3:0]  w_plen;
    logic [7:0]  w_pcode;
    logic [7:0]  w_pbyte;
    logic        w_full;
    logic        w_out_free;
    logic [7:0]  w_rx;
    logic [7:0]  w_ack;
    logic [11:0] w_hdr_rdata;
    logic [7:0]  w_pay_rdata;
    logic [PAW-1:0] w_pay_waddr;
    logic [PAW-1:0] w_pay_raddr;
    logic [PW-1:0]  w_head_next;
    logic [PW-1:0]  w_tail_next;

    assign w_payload  = {r_item.payload_high, r_item.payload_low};
    assign w_full     = (r_count >= CW'(QUEUE_DEPTH));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_rx       = r_item.rx_byte;
    assign w_ack      = BYTE_ACK | {7'd0, r_rx_phase};
    assign w_head_next = (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + PW'(1);
    assign w_tail_next = (r_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PW'(1);

    // Length, code and bytes of the command being written to the queue.
    always_comb begin
        w_plen  = 4'd0;
        w_pcode = 8'd0;
        w_pbyte = 8'd0;
        case (r_push_src)
            SRC_HOST: begin
                w_plen  = (r_item.cmd_len > 4'(MAX_PAYLOAD)) ? 4'(MAX_PAYLOAD)
                                                             : r_item.cmd_len;
                w_pcode = r_item.cmd_code;
                w_pbyte = w_payload[r_idx * 8 +: 8];
            end
            SRC_INIT: begin
                w_plen  = 4'd3;
                w_pcode = CODE_INIT;
                w_pbyte = 8'h01;
            end
            SRC_ID: begin
                w_plen  = 4'd4;
                w_pcode = CODE_ID;
                w_pbyte = id_byte(r_idx);
            end
            SRC_KEYS: begin
                w_plen  = 4'd2;
                w_pcode = CODE_KEYS;
                w_pbyte = 8'h00;
            end
            default: w_plen = 4'd0;
        endcase
    end

    assign w_pay_waddr = PAW'(PAW'(r_tail) * PAW'(MAX_PAYLOAD) + PAW'(r_idx));
    assign w_pay_raddr = PAW'(PAW'(r_head) * PAW'(MAX_PAYLOAD) + PAW'(r_idx));

    rlfe_ram #(
        .WIDTH (12),
        .DEPTH (QUEUE_DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_hdr && !w_full),
        .i_waddr (r_tail),
        .i_wdata ({w_pcode, w_plen}),
        .i_raddr (r_head),
        .o_rdata (w_hdr_rdata)
    );

    rlfe_ram #(
        .WIDTH (8),
        .DEPTH (PAD)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_byte),
        .i_waddr (w_pay_waddr),
        .i_wdata (w_pbyte),
        .i_raddr (w_pay_raddr),
        .o_rdata (w_pay_rdata)
    );

    always_comb begin
        n_online     = r_online;
        n_rts        = r_rts;
        n_cts        = r_cts;
        n_await      = r_await;
        n_rx_phase   = r_rx_phase;
        n_tx_phase   = r_tx_phase;
        n_parse      = r_parse;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_fault      = r_fault;
        n_cmd_valid  = r_cmd_valid;
        n_cmd        = r_cmd;
        n_push_src   = r_push_src;
        n_plan_send  = r_plan_send;
        n_emit1_v    = r_emit1_v;
        n_emit1_byte = r_emit1_byte;
        n_push_ok    = r_push_ok;
        n_idx        = r_idx;
        n_ck         = r_ck;
        n_flen       = r_flen;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        if (i_cmd.decode) begin
            n_fault      = FAULT_NONE;
            n_cmd_valid  = 1'b0;
            n_cmd        = 8'd0;
            n_push_src   = SRC_NONE;
            n_plan_send  = 1'b0;
            n_emit1_v    = 1'b0;
            n_emit1_byte = 8'd0;
            case (r_item.kind)
                KIND_TICK: begin
                    if (r_item.line_powered) begin
                        if (!r_online) begin
                            n_online   = 1'b1;
                            n_rts      = 1'b0;
                            n_cts      = 1'b0;
                            n_await    = 1'b0;
                            n_parse    = PS_IDLE;
                            n_head     = '0;
                            n_tail     = '0;
                            n_count    = '0;
                            n_push_src = SRC_INIT;
                        end
                        n_plan_send = 1'b1;
                    end else begin
                        n_online = 1'b0;
                        n_rts    = 1'b0;
                        n_cts    = 1'b0;
                        n_await  = 1'b0;
                    end
                end
                KIND_RX: begin
                    case (r_parse)
                        PS_CODE: begin
                            n_rx_phase  = w_rx[0];
                            n_cmd_valid = 1'b1;
                            n_cmd       = w_rx;
                            n_parse     = ((w_rx & PHASE_MASK) == CODE_QUERY) ? PS_ARG
                                                                             : PS_SKIP;
                        end
                        PS_ARG: begin
                            if (w_rx == QUERY_ARG_KEYS) n_push_src = SRC_KEYS;
                            n_parse = PS_CHK;
                        end
                        PS_CHK: n_parse = PS_END;
                        PS_END: begin
                            if (w_rx != BYTE_EOF) n_fault = FAULT_NO_END;
                            n_emit1_v    = 1'b1;
                            n_emit1_byte = w_ack;
                            n_rts        = 1'b0;
                            n_parse      = PS_IDLE;
                        end
                        PS_SKIP: begin
                            if (w_rx == BYTE_EOF) begin
                                n_emit1_v    = 1'b1;
                                n_emit1_byte = w_ack;
                                n_rts        = 1'b0;
                                n_parse      = PS_IDLE;
                            end
                        end
                        default: begin
                            n_parse = PS_IDLE;
                            if (w_rx == BYTE_RTS) begin
                                n_rts        = 1'b1;
                                n_emit1_v    = 1'b1;
                                n_emit1_byte = BYTE_CTS;
                            end else if (w_rx == BYTE_CTS) begin
                                n_cts = 1'b1;
                            end else if (w_rx == BYTE_ACK || w_rx == BYTE_ACK_ODD) begin
                                n_cts = 1'b0;
                                if (!r_await) begin
                                    n_fault = FAULT_UNEXP_ACK;
                                end else begin
                                    n_await = 1'b0;
                                    if (r_count != '0) begin
                                        n_head  = w_head_next;
                                        n_count = r_count - CW'(1);
                                    end
                                    if (w_rx[0] != r_tx_phase) n_fault = FAULT_ACK_PHASE;
                                    else                       n_tx_phase = !r_tx_phase;
                                end
                            end else if (w_rx == BYTE_SOF) begin
                                n_parse = PS_CODE;
                            end
                        end
                    endcase
                end
                KIND_HOST: n_push_src = SRC_HOST;
                default:   n_plan_send = 1'b0;
            endcase
        end

        if (i_cmd.push_hdr) begin
            n_idx = '0;
            if (w_full) begin
                n_fault   = FAULT_QUEUE_FULL;
                n_push_ok = 1'b0;
            end else begin
                n_push_ok = 1'b1;
            end
        end

        if (i_cmd.push_byte) begin
            n_idx = r_idx + IW'(1);
        end

        if (i_cmd.push_end) begin
            if (r_push_ok) begin
                n_tail  = w_tail_next;
                n_count = r_count + CW'(1);
            end
            n_push_src = (r_push_src == SRC_INIT) ? SRC_ID : SRC_NONE;
        end

        if (i_cmd.rts_req) begin
            n_emit1_v    = 1'b1;
            n_emit1_byte = BYTE_RTS;
        end

        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        if (i_cmd.emit && w_out_free) begin
            n_out_valid        = 1'b1;
            n_out.tx_valid     = 1'b1;
            n_out.tx_byte      = 8'd0;
            n_out.last         = 1'b0;
            n_out.link_online  = r_online;
            n_out.fault        = r_fault;
            n_out.rx_cmd_valid = r_cmd_valid;
            n_out.rx_cmd       = r_cmd;
            n_out.queue_level  = 5'(r_count);
            case (i_cmd.emit_sel)
                EM_SINGLE: begin
                    n_out.tx_valid = r_emit1_v;
                    n_out.tx_byte  = r_emit1_v ? r_emit1_byte : 8'd0;
                    n_out.last     = 1'b1;
                end
                EM_SOF: begin
                    n_out.tx_byte = BYTE_SOF;
                    n_ck          = w_hdr_rdata[11:4] | {7'd0, r_tx_phase};
                    n_flen        = (w_hdr_rdata[3:0] > 4'(MAX_PAYLOAD)) ? 4'(MAX_PAYLOAD)
                                                                         : w_hdr_rdata[3:0];
                    n_idx         = '0;
                end
                EM_CODE: n_out.tx_byte = r_ck;
                EM_DATA: begin
                    n_out.tx_byte = w_pay_rdata;
                    n_ck          = r_ck ^ w_pay_rdata;
                    n_idx         = r_idx + IW'(1);
                end
                EM_CHECK: n_out.tx_byte = r_ck;
                EM_EOF: begin
                    n_out.tx_byte = BYTE_EOF;
                    n_out.last    = 1'b1;
                    n_await       = 1'b1;
                    n_rts         = 1'b0;
                end
                default: n_out.tx_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_online     <= 1'b0;
            r_rts        <= 1'b0;
            r_cts        <= 1'b0;
            r_await      <= 1'b0;
            r_rx_phase   <= 1'b0;
            r_tx_phase   <= 1'b0;
            r_parse      <= PS_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_fault      <= FAULT_NONE;
            r_cmd_valid  <= 1'b0;
            r_cmd        <= 8'd0;
            r_push_src   <= SRC_NONE;
            r_plan_send  <= 1'b0;
            r_emit1_v    <= 1'b0;
            r_emit1_byte <= 8'd0;
            r_push_ok    <= 1'b0;
            r_idx        <= '0;
            r_flen       <= 4'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_online     <= n_online;
            r_rts        <= n_rts;
            r_cts        <= n_cts;
            r_await      <= n_await;
            r_rx_phase   <= n_rx_phase;
            r_tx_phase   <= n_tx_phase;
            r_parse      <= n_parse;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_fault      <= n_fault;
            r_cmd_valid  <= n_cmd_valid;
            r_cmd        <= n_cmd;
            r_push_src   <= n_push_src;
            r_plan_send  <= n_plan_send;
            r_emit1_v    <= n_emit1_v;
            r_emit1_byte <= n_emit1_byte;
            r_push_ok    <= n_push_ok;
            r_idx        <= n_idx;
            r_flen       <= n_flen;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept) r_item <= i_in_data;
        r_ck  <= n_ck;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_status                = '0;
        o_status.push_src       = r_push_src;
        o_status.plan_send      = r_plan_send;
        o_status.push_stop      = w_full || (w_plen == 4'd0);
        o_status.push_idx_last  = (4'(r_idx) + 4'd1) == w_plen;
        o_status.send_skip      = (r_count == '0) || r_rts || r_await;
        o_status.cts            = r_cts;
        o_status.frame_empty    = (r_flen == 4'd0);
        o_status.frame_idx_last = (4'(r_idx) + 4'd1) == r_flen;
        o_status.out_free       = w_out_free;
    end

    `RLFE_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(QUEUE_DEPTH), "queue count above depth")
    `RLFE_ASSERT_ALWAYS(a_empty_ptrs, (r_count != '0) || (r_head == r_tail), "empty queue with pointers apart")
    `RLFE_ASSERT_NEXT(a_eof_awaits, i_cmd.emit && (i_cmd.emit_sel == EM_EOF) && w_out_free, r_await, "frame sent without awaiting ack")
endmodule

// ----- src/remote_link_frame_engine.sv -----
`timescale 1ns / 1ps
// Link engine for a half-duplex remote serial protocol. Each input transfer is a
// tick (carrying the line-power bit), a byte received from the partner, or a
// command the host wants queued; each item yields one or more output transfers,
// the final one marked by last, and every output of an item carries the link
// status after that item. A tick that brings the line up resets the link and
// queues an init and an id command; an online tick then sends RTS, or the head
// command as a frame (FD, code with phase bit, payload, XOR checksum, FE).
// Received bytes drive a small parser that answers RTS with CTS, retires the
// head command on a phase-checked ACK and acknowledges incoming frames.
// Items are handled one at a time by a controller state machine sequencing a
// datapath; the queue lives in two single-port-read RAMs (header and payload).
// Sequence per item: a status-only item is decoded, planned and given a final emit;
// sending RTS adds a send check; each enqueue adds a header write, the byte writes,
// a tail update and a fresh plan; a frame replaces the final emit with a header
// read wait and the frame bytes, and every payload byte waits for the registered
// payload RAM read. Output stalls hold the sequence; the next input is taken in
// the cycle after the last output is loaded into the output register.
module remote_link_frame_engine import rlfe_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rlfe_in_if.sink         i_in,
    rlfe_out_if.source      o_out
);
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    // Controller owns sequencing: accept, decode, queue writes, frame emission.
    rlfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath holds link flags, parser, queue and the output register.
    rlfe_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (i_in.valid && w_in_ready),
        .i_in_data   (i_in.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

    assign i_in.ready = w_in_ready;
endmodule

// ----- bench/remote_link_frame_engine_test.sv -----
`timescale 1ns / 1ps
module remote_link_frame_engine_test;
    import rlfe_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rlfe_in_if  in_ch ();
    rlfe_out_if out_ch ();

    remote_link_frame_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the link state
    logic       lk_online, lk_rts, lk_cts, lk_wait_ack, lk_rx_phase, lk_tx_phase;
    t_parse     lk_parse;
    int         lk_head, lk_tail, lk_count;
    logic [7:0] lk_code [QUEUE_DEPTH_DEF];
    int         lk_len [QUEUE_DEPTH_DEF];
    logic [7:0] lk_bytes [QUEUE_DEPTH_DEF][MAX_PAYLOAD_DEF];

    t_out_item  link_out_q[$];
    logic [7:0] tx_buf[$];

    int  errors = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;

    function automatic t_fault enqueue_cmd(input logic [7:0] code, input int len,
                                           input logic [7:0] pl [MAX_PAYLOAD_DEF]);
        if (lk_count >= QUEUE_DEPTH_DEF) return FAULT_QUEUE_FULL;
        if (len > MAX_PAYLOAD_DEF) len = MAX_PAYLOAD_DEF;
        lk_code[lk_tail] = code;
        lk_len[lk_tail] = len;
        for (int i = 0; i < len; i++) lk_bytes[lk_tail][i] = pl[i];
        lk_tail = (lk_tail + 1) % QUEUE_DEPTH_DEF;
        lk_count++;
        return FAULT_NONE;
    endfunction

    function automatic void send_head();
        logic [7:0] ck;
        int h;
        if (lk_count == 0 || lk_rts || lk_wait_ack) return;
        if (!lk_cts) begin
            tx_buf.push_back(BYTE_RTS);
            return;
        end
        h = lk_head;
        ck = lk_code[h] | {7'd0, lk_tx_phase};
        tx_buf.push_back(BYTE_SOF);
        tx_buf.push_back(ck);
        for (int i = 0; i < lk_len[h]; i++) begin
            tx_buf.push_back(lk_bytes[h][i]);
            ck ^= lk_bytes[h][i];
        end
        tx_buf.push_back(ck);
        tx_buf.push_back(BYTE_EOF);
        lk_wait_ack = 1'b1;
        lk_rts = 1'b0;
    endfunction

    function automatic void ack_incoming();
        tx_buf.push_back(BYTE_ACK | {7'd0, lk_rx_phase});
        lk_rts = 1'b0;
        lk_parse = PS_IDLE;
    endfunction

    // Work out the output transfers that one input item causes
    function automatic void predict_link(input t_in_item it);
        t_fault     flt;
        logic       cv;
        logic [7:0] cmd, b;
        logic [7:0] pl [MAX_PAYLOAD_DEF];
        t_out_item  o;
        int         n;
        flt = FAULT_NONE;
        cv = 1'b0;
        cmd = 8'd0;
        tx_buf.delete();
        for (int i = 0; i < MAX_PAYLOAD_DEF; i++) pl[i] = 8'd0;
        case (it.kind)
            KIND_TICK: begin
                if (it.line_powered) begin
                    if (!lk_online) begin
                        lk_online = 1'b1;
                        lk_rts = 1'b0; lk_cts = 1'b0; lk_wait_ack = 1'b0;
                        lk_parse = PS_IDLE;
                        lk_head = 0; lk_tail = 0; lk_count = 0;
                        pl[0] = 8'h01; pl[1] = 8'h01; pl[2] = 8'h01;
                        void'(enqueue_cmd(CODE_INIT, 3, pl));
                        pl[0] = 8'h01; pl[1] = 8'hA8; pl[2] = 8'h00; pl[3] = 8'h47;
                        void'(enqueue_cmd(CODE_ID, 4, pl));
                    end
                    send_head();
                end else begin
                    lk_online = 1'b0;
                    lk_rts = 1'b0; lk_cts = 1'b0; lk_wait_ack = 1'b0;
                end
            end
            KIND_RX: begin
                b = it.rx_byte;
                case (lk_parse)
                    PS_CODE: begin
                        lk_rx_phase = b[0];
                        cv = 1'b1;
                        cmd = b;
                        lk_parse = ((b & PHASE_MASK) == CODE_QUERY) ? PS_ARG : PS_SKIP;
                    end
                    PS_ARG: begin
                        if (b == QUERY_ARG_KEYS) flt = enqueue_cmd(CODE_KEYS, 2, pl);
                        lk_parse = PS_CHK;
                    end
                    PS_CHK: lk_parse = PS_END;
                    PS_END: begin
                        if (b != BYTE_EOF) flt = FAULT_NO_END;
                        ack_incoming();
                    end
                    PS_SKIP: if (b == BYTE_EOF) ack_incoming();
                    default: begin
                        lk_parse = PS_IDLE;
                        if (b == BYTE_RTS) begin
                            lk_rts = 1'b1;
                            tx_buf.push_back(BYTE_CTS);
                        end else if (b == BYTE_CTS) begin
                            lk_cts = 1'b1;
                        end else if (b == BYTE_ACK || b == BYTE_ACK_ODD) begin
                            if (!lk_wait_ack) begin
                                flt = FAULT_UNEXP_ACK;
                                lk_cts = 1'b0;
                            end else begin
                                lk_wait_ack = 1'b0;
                                lk_cts = 1'b0;
                                if (lk_count > 0) begin
                                    lk_head = (lk_head + 1) % QUEUE_DEPTH_DEF;
                                    lk_count--;
                                end
                                if (b[0] != lk_tx_phase) flt = FAULT_ACK_PHASE;
                                else lk_tx_phase = ~lk_tx_phase;
                            end
                        end else if (b == BYTE_SOF) begin
                            lk_parse = PS_CODE;
                        end
                    end
                endcase
            end
            KIND_HOST: begin
                for (int i = 0; i < 8; i++) pl[i] = it.payload_low[8*i +: 8];
                pl[8] = it.payload_high[7:0];
                pl[9] = it.payload_high[15:8];
                flt = enqueue_cmd(it.cmd_code, int'(it.cmd_len), pl);
            end
            default: ;
        endcase
        n = (tx_buf.size() > 0) ? tx_buf.size() : 1;
        for (int k = 0; k < n; k++) begin
            o.tx_valid     = tx_buf.size() > 0;
            o.tx_byte      = (tx_buf.size() > 0) ? tx_buf[k] : 8'd0;
            o.last         = (k + 1 == n);
            o.link_online  = lk_online;
            o.fault        = flt;
            o.rx_cmd_valid = cv;
            o.rx_cmd       = cmd;
            o.queue_level  = lk_count[4:0];
            link_out_q.push_back(o);
        end
    endfunction

    function automatic bit idle_draw();
        return idle_on && ($urandom_range(99) < 26);
    endfunction

    // Hold each item until its transfer; predict on acceptance
    task automatic send_item(input t_in_item it);
        while (idle_draw()) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_link(it);
        @(negedge i_clk);
    endtask

    task automatic send_tick(input logic pwr);
        t_in_item it;
        it = '0;
        it.kind = KIND_TICK;
        it.line_powered = pwr;
        send_item(it);
    endtask

    task automatic send_rx(input logic [7:0] b);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom});
        it.kind = KIND_RX;
        it.rx_byte = b;
        send_item(it);
    endtask

    task automatic send_host(input logic [7:0] code, input logic [3:0] len);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom});
        it.kind = KIND_HOST;
        it.cmd_code = code;
        it.cmd_len = len;
        send_item(it);
    endtask

    // Incoming frame from the partner, optionally broken at the end
    task automatic send_frame(input logic [7:0] code, input logic [7:0] arg,
                              input bit bad_end);
        send_rx(BYTE_SOF);
        send_rx(code);
        send_rx(arg);
        if ((code & PHASE_MASK) == CODE_QUERY) send_rx($urandom_range(255));
        send_rx(bad_end ? 8'h5A : BYTE_EOF);
    endtask

    // Sample each output transfer at the rising edge
    always @(posedge i_clk) begin
        t_out_item got, want;
        cycles++;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (link_out_q.size() == 0) begin
                $display("%0t unexpected output %h", $time, got);
                errors++;
            end else begin
                want = link_out_q.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) out_ch.ready <= !idle_draw();

    always @(posedge i_clk) begin
        if (cycles > 400000) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        logic [7:0] c;
        send_tick(1'b0);
        send_rx(BYTE_ACK);                      // unexpected ack
        send_tick(1'b1);                        // online, RTS out
        send_rx(BYTE_CTS);
        send_tick(1'b1);                        // init frame
        send_rx(BYTE_ACK_ODD);                  // phase mismatch
        send_rx(BYTE_CTS);
        send_tick(1'b1);
        send_rx(BYTE_ACK);
        send_rx(BYTE_RTS);                      // answered with CTS
        send_host(8'hFE, 4'hF);                 // saturated length
        send_host(8'h00, 4'h0);
        send_frame(CODE_QUERY | 8'h01, QUERY_ARG_KEYS, 1'b1);
        send_frame(8'h44, 8'h33, 1'b0);
        send_rx(8'h11);
        for (int i = 0; i < 16; i++) begin
            c = 8'($urandom_range(127)) << 1;
            send_host(c, 4'($urandom_range(10)));
        end
        send_frame(CODE_QUERY, QUERY_ARG_KEYS, 1'b0); // queue full
        send_tick(1'b0);
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 320) begin
            idle_on = !(sent >= 150 && sent < 200);
            case ($urandom_range(9))
                0, 1: begin send_tick($urandom_range(9) != 0); sent++; end
                2: begin send_rx(BYTE_CTS); send_tick(1'b1); sent += 2; end
                3: begin send_rx($urandom_range(1) ? BYTE_ACK : BYTE_ACK_ODD); sent++; end
                4: begin
                    send_frame({7'($urandom_range(3) == 0 ? 1 : $urandom_range(127)),
                                1'($urandom_range(1))}, $urandom_range(1), $urandom_range(5) == 0);
                    sent += 5;
                end
                5: begin send_rx(BYTE_RTS); sent++; end
                6: begin
                    send_host($urandom_range(255), $urandom_range(15));
                    sent++;
                end
                7: begin send_rx($urandom_range(255)); sent++; end
                default: begin
                    // handshake: CTS, tick that may send a frame, ack usually matching the phase
                    send_rx(BYTE_CTS);
                    send_tick(1'b1);
                    send_rx(BYTE_ACK | {7'd0, lk_tx_phase ^ ($urandom_range(7) == 0)});
                    sent += 3;
                end
            endcase
        end
        idle_on = 1'b1;
    endtask

    initial begin
        t_in_item unused;
        unused = '0;
        unused.kind = 2'd3;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        lk_online = 0; lk_rts = 0; lk_cts = 0; lk_wait_ack = 0;
        lk_rx_phase = 0; lk_tx_phase = 0; lk_parse = PS_IDLE;
        lk_head = 0; lk_tail = 0; lk_count = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_item(unused);
        test_directed();
        test_random();
        in_ch.valid <= 1'b0;
        while (link_out_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
